// ===== sv/tgkc_pkg.sv =====
// Package for the two-generation keyed cache.
// Holds command codes, controller state codes and fixed port widths.
// No dependencies.
package tgkc_pkg;

    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam int STATE_W = 3;

    localparam logic [STATE_W-1:0] ST_CLEAR  = 3'd0;
    localparam logic [STATE_W-1:0] ST_IDLE   = 3'd1;
    localparam logic [STATE_W-1:0] ST_SCAN   = 3'd2;
    localparam logic [STATE_W-1:0] ST_REMOVE = 3'd3;
    localparam logic [STATE_W-1:0] ST_WRITE  = 3'd4;
    localparam logic [STATE_W-1:0] ST_SWEEP  = 3'd5;
    localparam logic [STATE_W-1:0] ST_DONE   = 3'd6;

endpackage

// ===== sv/two_generation_keyed_cache_unit.sv =====
// Two-generation keyed cache: two banks of key/value entries in one entry RAM.
// Depends on tgkc_pkg (command codes, state codes, port widths).
//
// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_ready  command, key, entry_value
// response  out        rsp_valid / rsp_ready  found, value_out, swapped
//
// One request at a time: an accept state, a scan of both banks through the entry
// RAM (one entry per cycle, registered read), write-back in ST_REMOVE and, for
// an insert, ST_WRITE, and a response state. An insert that swaps banks adds
// a sweep over the old bank. After reset a clearing pass over the whole entry
// RAM runs before the first request is taken.
// A full response register stalls a request only in its final state.
module two_generation_keyed_cache_unit #(
    parameter int MAX_ENTRIES = 63,
    parameter int KEY_WIDTH   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic                           command,
    input  logic [tgkc_pkg::KEY_BITS-1:0]  key,
    input  logic [tgkc_pkg::VALUE_BITS-1:0] entry_value,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic                           found,
    output logic [tgkc_pkg::VALUE_BITS-1:0] value_out,
    output logic                           swapped
);

    localparam int BANK_DEPTH = MAX_ENTRIES + 1;
    localparam int IW         = $clog2(BANK_DEPTH);
    localparam int AW         = IW + 1;
    localparam int MEM_DEPTH  = 2 ** AW;
    localparam int CW         = $clog2(MAX_ENTRIES + 2);
    localparam int KW         = KEY_WIDTH;
    localparam int DW         = (VALUE_WIDTH < tgkc_pkg::VALUE_BITS) ?
                                VALUE_WIDTH : tgkc_pkg::VALUE_BITS;
    localparam int EW         = 1 + KW + DW;

    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_ENTRIES);

    // entry RAM: {valid, key, data}
    logic [EW-1:0] mem [0:MEM_DEPTH-1];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [tgkc_pkg::STATE_W-1:0] state_reg, state_next;
    logic          recent_reg, recent_next;
    logic [CW-1:0] cnt0_reg, cnt0_next;
    logic [CW-1:0] cnt1_reg, cnt1_next;
    logic          issue_reg, issue_next;
    logic          p_valid_reg, p_valid_next;
    logic          hit_reg, hit_next;
    logic          free_found_reg, free_found_next;
    logic          swap_reg, swap_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic          cmd_reg, cmd_next;
    logic [KW-1:0] key_reg, key_next;
    logic [DW-1:0] val_reg, val_next;
    logic          scan_bank_reg, scan_bank_next;
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic          p_bank_reg, p_bank_next;
    logic [IW-1:0] p_idx_reg, p_idx_next;
    logic          hit_bank_reg, hit_bank_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [DW-1:0] hit_data_reg, hit_data_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          found_reg, found_next;
    logic [tgkc_pkg::VALUE_BITS-1:0] value_out_reg, value_out_next;
    logic          swapped_reg, swapped_next;

    logic          e_valid;
    logic [KW-1:0] e_key;
    logic [DW-1:0] e_data;
    logic [CW-1:0] cnt_recent;
    logic          new_key;
    logic [CW-1:0] cnt_recent_new;

    assign e_valid    = rd_data_reg[EW-1];
    assign e_key      = rd_data_reg[DW +: KW];
    assign e_data     = rd_data_reg[DW-1:0];
    assign cnt_recent = recent_reg ? cnt1_reg : cnt0_reg;
    assign new_key    = !(hit_reg && (hit_bank_reg == recent_reg));
    assign cnt_recent_new = new_key ? cnt_recent + CW'(1) : cnt_recent;

    assign req_ready = (state_reg == tgkc_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign found     = found_reg;
    assign value_out = value_out_reg;
    assign swapped   = swapped_reg;
    assign mem_raddr = {scan_bank_reg, scan_idx_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        recent_next     = recent_reg;
        cnt0_next       = cnt0_reg;
        cnt1_next       = cnt1_reg;
        issue_next      = issue_reg;
        p_valid_next    = 1'b0;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        swap_next       = swap_reg;
        rsp_valid_next  = rsp_valid_reg;
        clr_addr_next   = clr_addr_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        scan_bank_next  = scan_bank_reg;
        scan_idx_next   = scan_idx_reg;
        p_bank_next     = p_bank_reg;
        p_idx_next      = p_idx_reg;
        hit_bank_next   = hit_bank_reg;
        hit_idx_next    = hit_idx_reg;
        hit_data_next   = hit_data_reg;
        free_idx_next   = free_idx_reg;
        found_next      = found_reg;
        value_out_next  = value_out_reg;
        swapped_next    = swapped_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            tgkc_pkg::ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (&clr_addr_reg)
                begin
                    state_next = tgkc_pkg::ST_IDLE;
                end
            end
            tgkc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next        = command;
                    key_next        = key[KW-1:0];
                    val_next        = entry_value[DW-1:0];
                    scan_bank_next  = 1'b0;
                    scan_idx_next   = '0;
                    issue_next      = 1'b1;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    swap_next       = 1'b0;
                    state_next      = tgkc_pkg::ST_SCAN;
                end
            end
            tgkc_pkg::ST_SCAN:
            begin
                if (issue_reg)
                begin
                    p_valid_next = 1'b1;
                    p_bank_next  = scan_bank_reg;
                    p_idx_next   = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        scan_idx_next = '0;
                        if (scan_bank_reg)
                        begin
                            issue_next = 1'b0;
                        end
                        else
                        begin
                            scan_bank_next = 1'b1;
                        end
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IW'(1);
                    end
                end
                if (p_valid_reg)
                begin
                    if (e_valid && (e_key == key_reg))
                    begin
                        hit_next      = 1'b1;
                        hit_bank_next = p_bank_reg;
                        hit_idx_next  = p_idx_reg;
                        hit_data_next = e_data;
                    end
                    if (!e_valid && (p_bank_reg == recent_reg) && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = p_idx_reg;
                    end
                    if (!issue_reg)
                    begin
                        state_next = tgkc_pkg::ST_REMOVE;
                    end
                end
            end
            tgkc_pkg::ST_REMOVE:
            begin
                if (hit_reg && ((cmd_reg == tgkc_pkg::CMD_LOOKUP) ||
                                (hit_bank_reg != recent_reg)))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {hit_bank_reg, hit_idx_reg};
                    if (hit_bank_reg)
                    begin
                        cnt1_next = cnt1_reg - CW'(1);
                    end
                    else
                    begin
                        cnt0_next = cnt0_reg - CW'(1);
                    end
                end
                state_next = (cmd_reg == tgkc_pkg::CMD_LOOKUP) ?
                             tgkc_pkg::ST_DONE : tgkc_pkg::ST_WRITE;
            end
            tgkc_pkg::ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, key_reg, val_reg};
                mem_waddr = new_key ? {recent_reg, free_idx_reg} :
                                      {recent_reg, hit_idx_reg};
                if (recent_reg)
                begin
                    cnt1_next = cnt_recent_new;
                end
                else
                begin
                    cnt0_next = cnt_recent_new;
                end
                scan_idx_next = '0;
                state_next    = (cnt_recent_new > CNT_MAX) ?
                                tgkc_pkg::ST_SWEEP : tgkc_pkg::ST_DONE;
            end
            tgkc_pkg::ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = {~recent_reg, scan_idx_reg};
                if (scan_idx_reg == LAST_IDX)
                begin
                    if (recent_reg)
                    begin
                        cnt0_next = '0;
                    end
                    else
                    begin
                        cnt1_next = '0;
                    end
                    recent_next = ~recent_reg;
                    swap_next   = 1'b1;
                    state_next  = tgkc_pkg::ST_DONE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
            end
            tgkc_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = (cmd_reg == tgkc_pkg::CMD_LOOKUP) && hit_reg;
                    value_out_next = found_next ?
                                     tgkc_pkg::VALUE_BITS'(hit_data_reg) : '0;
                    swapped_next   = swap_reg;
                    state_next     = tgkc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tgkc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tgkc_pkg::ST_CLEAR;
            recent_reg     <= 1'b1;
            cnt0_reg       <= '0;
            cnt1_reg       <= '0;
            issue_reg      <= 1'b0;
            p_valid_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            swap_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            clr_addr_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            recent_reg     <= recent_next;
            cnt0_reg       <= cnt0_next;
            cnt1_reg       <= cnt1_next;
            issue_reg      <= issue_next;
            p_valid_reg    <= p_valid_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            swap_reg       <= swap_next;
            rsp_valid_reg  <= rsp_valid_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        scan_bank_reg <= scan_bank_next;
        scan_idx_reg  <= scan_idx_next;
        p_bank_reg    <= p_bank_next;
        p_idx_reg     <= p_idx_next;
        hit_bank_reg  <= hit_bank_next;
        hit_idx_reg   <= hit_idx_next;
        hit_data_reg  <= hit_data_next;
        free_idx_reg  <= free_idx_next;
        found_reg     <= found_next;
        value_out_reg <= value_out_next;
        swapped_reg   <= swapped_next;
    end

endmodule

// ===== bench/tgkc_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the two-generation keyed cache: mirrors both banks,
// predicts one response per accepted request and compares it field by field.
// Depends on tgkc_pkg for command codes and port widths.
module tgkc_checker #(
    parameter int MAX_ENTRIES = 63
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  logic                            command,
    input  logic [tgkc_pkg::KEY_BITS-1:0]   key,
    input  logic [tgkc_pkg::VALUE_BITS-1:0] entry_value,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  logic                            found,
    input  logic [tgkc_pkg::VALUE_BITS-1:0] value_out,
    input  logic                            swapped,
    output int                              mismatch_count,
    output int                              awaiting
);

    localparam int BANK_SLOTS = MAX_ENTRIES + 1;

    typedef struct packed {
        logic                            found;
        logic [tgkc_pkg::VALUE_BITS-1:0] value;
        logic                            swapped;
    } cache_reply_t;

    bit                              slot_valid [2*BANK_SLOTS];
    logic [tgkc_pkg::KEY_BITS-1:0]   slot_key   [2*BANK_SLOTS];
    logic [tgkc_pkg::VALUE_BITS-1:0] slot_data  [2*BANK_SLOTS];
    bit                              recent_bank;
    int                              bank_fill  [2];
    cache_reply_t                    reply_queue [$];

    function automatic int bank_base(bit bank);
        return bank ? BANK_SLOTS : 0;
    endfunction

    function automatic int find_slot(bit bank, logic [tgkc_pkg::KEY_BITS-1:0] k);
        int base;
        base = bank_base(bank);
        for (int i = 0; i < BANK_SLOTS; i++)
            if (slot_valid[base+i] && slot_key[base+i] == k)
                return base + i;
        return -1;
    endfunction

    function automatic cache_reply_t cache_step(logic cmd,
                                                logic [tgkc_pkg::KEY_BITS-1:0] k,
                                                logic [tgkc_pkg::VALUE_BITS-1:0] v);
        cache_reply_t r;
        int           slot;
        int           base;
        bit           old_bank;
        bit           placed;
        r = '0;
        old_bank = !recent_bank;
        if (cmd == tgkc_pkg::CMD_INSERT)
        begin
            slot = find_slot(old_bank, k);
            if (slot >= 0)
            begin
                slot_valid[slot] = 1'b0;
                bank_fill[old_bank]--;
            end
            slot = find_slot(recent_bank, k);
            if (slot >= 0)
                slot_data[slot] = v;
            else
            begin
                // new key takes the lowest free slot of the recent bank
                base = bank_base(recent_bank);
                placed = 1'b0;
                for (int i = 0; i < BANK_SLOTS && !placed; i++)
                    if (!slot_valid[base+i])
                    begin
                        slot_valid[base+i] = 1'b1;
                        slot_key[base+i]   = k;
                        slot_data[base+i]  = v;
                        bank_fill[recent_bank]++;
                        placed = 1'b1;
                    end
            end
            if (bank_fill[recent_bank] > MAX_ENTRIES)
            begin
                base = bank_base(old_bank);
                for (int i = 0; i < BANK_SLOTS; i++)
                    slot_valid[base+i] = 1'b0;
                bank_fill[old_bank] = 0;
                recent_bank = old_bank;
                r.swapped = 1'b1;
            end
        end
        else
        begin
            for (int b = 0; b < 2 && !r.found; b++)
            begin
                slot = find_slot(b[0], k);
                if (slot >= 0)
                begin
                    r.found = 1'b1;
                    r.value = slot_data[slot];
                    slot_valid[slot] = 1'b0;
                    bank_fill[b]--;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cache_reply_t seen;
        cache_reply_t want;
        if (!rst_n)
        begin
            foreach (slot_valid[i])
                slot_valid[i] = 1'b0;
            recent_bank  = 1'b1;
            bank_fill[0] = 0;
            bank_fill[1] = 0;
            reply_queue.delete();
            awaiting = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                seen.found   = found;
                seen.value   = value_out;
                seen.swapped = swapped;
                if (reply_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response: found=%0b value=%h swapped=%0b",
                                 seen.found, seen.value, seen.swapped);
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (seen !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp found=%0b value=%h swapped=%0b,",
                                     want.found, want.value, want.swapped,
                                     " got found=%0b value=%h swapped=%0b",
                                     seen.found, seen.value, seen.swapped);
                    end
                end
            end
            if (req_valid && req_ready)
                reply_queue.push_back(cache_step(command, key, entry_value));
            awaiting = reply_queue.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the keyed cache bench: clock, reset, request and response drivers.
// Depends on tgkc_pkg, two_generation_keyed_cache_unit and tgkc_checker.
module tb_top;

    localparam int RANDOM_ITEMS = 1638;
    localparam int POOL_SIZE    = 128;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            req_valid   = 1'b0;
    logic                            command     = tgkc_pkg::CMD_INSERT;
    logic [tgkc_pkg::KEY_BITS-1:0]   key         = '0;
    logic [tgkc_pkg::VALUE_BITS-1:0] entry_value = '0;
    logic                            rsp_ready   = 1'b0;
    logic                            req_ready;
    logic                            rsp_valid;
    logic                            found;
    logic [tgkc_pkg::VALUE_BITS-1:0] value_out;
    logic                            swapped;
    int                              mismatch_count;
    int                              awaiting;
    bit                              steady;
    bit                              hold_due;
    logic [tgkc_pkg::KEY_BITS-1:0]   key_pool [POOL_SIZE];

    always #1 clk = ~clk;

    two_generation_keyed_cache_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .command    (command),
        .key        (key),
        .entry_value(entry_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .found      (found),
        .value_out  (value_out),
        .swapped    (swapped)
    );

    tgkc_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .command       (command),
        .key           (key),
        .entry_value   (entry_value),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .found         (found),
        .value_out     (value_out),
        .swapped       (swapped),
        .mismatch_count(mismatch_count),
        .awaiting      (awaiting)
    );

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic issue(logic cmd, logic [tgkc_pkg::KEY_BITS-1:0] k,
                         logic [tgkc_pkg::VALUE_BITS-1:0] v);
        int gap;
        gap = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid   <= 1'b1;
        command     <= cmd;
        key         <= k;
        entry_value <= v;
        do @(posedge clk); while (!req_ready);
    endtask

    initial
    begin : drain
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_due)
            begin
                // long hold-off: the response register fills and the cache stalls its request side
                hold_due = 1'b0;
                repeat (400) @(negedge clk) rsp_ready <= 1'b0;
            end
            stall = draw_gap();
            repeat (stall) @(negedge clk) rsp_ready <= 1'b0;
            @(negedge clk) rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin : stimulus
        logic [tgkc_pkg::KEY_BITS-1:0] k;
        logic                          cmd;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        issue(tgkc_pkg::CMD_LOOKUP, '0, '0);
        issue(tgkc_pkg::CMD_INSERT, '0, '0);
        issue(tgkc_pkg::CMD_INSERT, '1, '1);
        issue(tgkc_pkg::CMD_INSERT, '1, 32'h5a5a_c3c3);
        issue(tgkc_pkg::CMD_LOOKUP, '1, '1);
        issue(tgkc_pkg::CMD_LOOKUP, '1, '0);
        issue(tgkc_pkg::CMD_LOOKUP, '0, 32'hffff_0000);
        issue(tgkc_pkg::CMD_INSERT, 64'h8000_0000_0000_0001, 32'ha5a5_0f0f);
        issue(tgkc_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0001, 32'h1234_5678);
        issue(tgkc_pkg::CMD_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
        issue(tgkc_pkg::CMD_INSERT, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
        issue(tgkc_pkg::CMD_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                steady = ($urandom_range(0, 4) == 0);
            if (n == 300)
                hold_due = 1'b1;
            k = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                             : key_pool[$urandom_range(0, POOL_SIZE-1)];
            cmd = ($urandom_range(0, 99) < 55) ? tgkc_pkg::CMD_INSERT
                                               : tgkc_pkg::CMD_LOOKUP;
            issue(cmd, k, $urandom);
        end
        @(negedge clk) req_valid <= 1'b0;
        wait (awaiting == 0);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && awaiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
